// ----- design/u8tr_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16LE transcoder.
`default_nettype none
package u8tr_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 18;
    localparam int QUEUE_DEPTH         = 4;
    localparam int SIZE_WIDTH          = 18;

    localparam logic [1:0] ST_UNIT      = 2'd0;
    localparam logic [1:0] ST_TERM      = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    localparam logic [15:0] HI_SURROGATE = 16'hD800;
    localparam logic [15:0] LO_SURROGATE = 16'hDC00;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [15:0]           code_unit;
        logic [1:0]            status;
        logic                  last_of_string;
        logic [SIZE_WIDTH-1:0] padded_size;
    } t_out;

    // One queued command: zero, one or two code units, then an optional
    // closing beat (terminator or error).
    typedef struct packed {
        logic                  unit_v;
        logic                  pair;
        logic [15:0]           first_unit;
        logic [15:0]           second_unit;
        logic                  tail_v;
        logic [1:0]            tail_status;
        logic [SIZE_WIDTH-1:0] tail_size;
    } t_cmd;

endpackage
`default_nettype wire

// ----- design/u8tr_front.sv -----
// Front end: accepts UTF-8 bytes, decodes sequences and builds output commands.
`default_nettype none
module u8tr_front #(
    parameter int COUNT_WIDTH = u8tr_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_accept,
    input  u8tr_pkg::t_in   i_data,
    output logic            o_push,
    output u8tr_pkg::t_cmd  o_cmd
);

    logic [2:0]             r_rem,     n_rem;
    logic [30:0]            r_acc,     n_acc;
    logic [COUNT_WIDTH-1:0] r_total,   n_total;
    logic                   r_discard, n_discard;

    logic [7:0]                  c;
    logic                        eos;
    logic                        done;
    logic                        err_v;
    logic [1:0]                  err_code;
    logic [2:0]                  add;
    logic [COUNT_WIDTH:0]        sum;
    logic [COUNT_WIDTH:0]        rounded;
    logic [COUNT_WIDTH:0]        padded;
    logic [COUNT_WIDTH:0]        cap;
    logic [COUNT_WIDTH+u8tr_pkg::SIZE_WIDTH:0] size_wide;
    logic [19:0]                 v;

    assign c   = i_data.utf8_byte;
    assign eos = i_data.end_of_string;
    assign cap = {1'b0, {(COUNT_WIDTH-2){1'b1}}, 2'b00};

    always_comb begin
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_total   = r_total;
        n_discard = r_discard;
        o_cmd     = '0;
        done      = 1'b0;
        err_v     = 1'b0;
        err_code  = u8tr_pkg::ST_MALFORMED;
        add       = 3'd0;
        v         = 20'd0;
        sum       = '0;
        rounded   = '0;
        padded    = '0;
        size_wide = '0;

        if (i_accept) begin
            if (r_discard) begin
                if (eos) begin
                    n_rem     = 3'd0;
                    n_acc     = 31'd0;
                    n_total   = '0;
                    n_discard = 1'b0;
                end
            end else begin
                if (r_rem == 3'd0) begin
                    if (c < 8'h80) begin
                        n_acc = {23'd0, c};
                        done  = 1'b1;
                    end else if (c < 8'hC0 || c > 8'hFD) begin
                        err_v = 1'b1;
                    end else if (c < 8'hE0) begin
                        n_acc = {26'd0, c[4:0]};
                        n_rem = 3'd1;
                    end else if (c < 8'hF0) begin
                        n_acc = {27'd0, c[3:0]};
                        n_rem = 3'd2;
                    end else if (c < 8'hF8) begin
                        n_acc = {28'd0, c[2:0]};
                        n_rem = 3'd3;
                    end else if (c < 8'hFC) begin
                        n_acc = {29'd0, c[1:0]};
                        n_rem = 3'd4;
                    end else begin
                        n_acc = {30'd0, c[0]};
                        n_rem = 3'd5;
                    end
                end else begin
                    if (c[7:6] != 2'b10) begin
                        err_v = 1'b1;
                    end else begin
                        n_acc = {r_acc[24:0], c[5:0]};
                        n_rem = r_rem - 3'd1;
                        done  = (r_rem == 3'd1);
                    end
                end

                if (done) begin
                    if (n_acc[30:16] == 15'd0) begin
                        o_cmd.unit_v     = 1'b1;
                        o_cmd.first_unit = n_acc[15:0];
                        add              = 3'd2;
                    end else if (n_acc[30:20] == 11'd0 && n_acc[19:16] != 4'hF) begin
                        v                 = n_acc[19:0] - 20'h10000;
                        o_cmd.unit_v      = 1'b1;
                        o_cmd.pair        = 1'b1;
                        o_cmd.first_unit  = u8tr_pkg::HI_SURROGATE | {6'd0, v[19:10]};
                        o_cmd.second_unit = u8tr_pkg::LO_SURROGATE | {6'd0, v[9:0]};
                        add               = 3'd4;
                    end else begin
                        err_v    = 1'b1;
                        err_code = u8tr_pkg::ST_RANGE;
                    end
                    n_acc = 31'd0;
                end

                // Saturating count of UTF-16 bytes in this string.
                sum     = {1'b0, r_total} + {{(COUNT_WIDTH-2){1'b0}}, add};
                n_total = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

                if (!err_v && eos && n_rem != 3'd0) begin
                    err_v = 1'b1;
                end

                rounded   = {1'b0, n_total} + {{(COUNT_WIDTH-2){1'b0}}, 3'd7};
                padded    = {rounded[COUNT_WIDTH:2], 2'b00};
                if (padded > cap) begin
                    padded = cap;
                end
                size_wide = {{u8tr_pkg::SIZE_WIDTH{1'b0}}, padded};

                if (err_v) begin
                    o_cmd.tail_v      = 1'b1;
                    o_cmd.tail_status = err_code;
                    o_cmd.tail_size   = '0;
                end else if (eos) begin
                    o_cmd.tail_v      = 1'b1;
                    o_cmd.tail_status = u8tr_pkg::ST_TERM;
                    o_cmd.tail_size   = size_wide[u8tr_pkg::SIZE_WIDTH-1:0];
                end

                if (eos) begin
                    n_rem     = 3'd0;
                    n_acc     = 31'd0;
                    n_total   = '0;
                    n_discard = 1'b0;
                end else if (err_v) begin
                    n_discard = 1'b1;
                end
            end
        end
    end

    assign o_push = i_accept && (o_cmd.unit_v || o_cmd.tail_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= 3'd0;
            r_acc     <= 31'd0;
            r_total   <= '0;
            r_discard <= 1'b0;
        end else begin
            r_rem     <= n_rem;
            r_acc     <= n_acc;
            r_total   <= n_total;
            r_discard <= n_discard;
        end
    end

endmodule
`default_nettype wire

// ----- design/u8tr_queue.sv -----
// Short command queue between the decoder and the output sequencer.
`default_nettype none
module u8tr_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  u8tr_pkg::t_cmd  i_cmd,
    input  wire             i_pop,
    output u8tr_pkg::t_cmd  o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int DEPTH = u8tr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8tr_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- design/u8tr_back.sv -----
// Back end: expands queued commands into output beats through an output register.
`default_nettype none
module u8tr_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  u8tr_pkg::t_cmd  i_head,
    input  wire             i_empty,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output u8tr_pkg::t_out  o_out_data
);

    logic           r_valid, n_valid;
    u8tr_pkg::t_out r_out,   n_out;
    logic [1:0]     r_phase, n_phase;

    logic       load;
    logic [1:0] units;
    logic [1:0] last_phase;

    assign load       = !r_valid || !i_out_stall;
    assign units      = i_head.unit_v ? (i_head.pair ? 2'd2 : 2'd1) : 2'd0;
    assign last_phase = units + {1'b0, i_head.tail_v} - 2'd1;

    always_comb begin
        n_valid = r_valid;
        n_out   = r_out;
        n_phase = r_phase;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_out = '0;
                if (r_phase < units) begin
                    n_out.code_unit = (r_phase == 2'd0) ? i_head.first_unit
                                                        : i_head.second_unit;
                    n_out.status    = u8tr_pkg::ST_UNIT;
                end else begin
                    n_out.status         = i_head.tail_status;
                    n_out.last_of_string = 1'b1;
                    n_out.padded_size    = i_head.tail_size;
                end
                if (r_phase == last_phase) begin
                    o_pop   = 1'b1;
                    n_phase = 2'd0;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- design/utf8_to_utf16le_transcoder.sv -----
// Top level of the UTF-8 to UTF-16LE transcoder: decoder, command queue, output sequencer.
//
//   Channel   Direction   Handshake                    Beat payload
//   input     in          i_in_valid / o_in_stall      utf8_byte, end_of_string
//   output    out         o_out_valid / i_out_stall    code_unit, status, last_of_string,
//                                                      padded_size
//
// The decoder takes one byte per cycle; it stalls the input only when the
// command queue is full. Each byte that yields results leaves one queue entry.
// The output sequencer sends one beat per cycle from its output register while
// the output is not stalled, so a byte finishing a surrogate pair costs two output
// beats and a string end after a unit adds one more; the queue absorbs these bursts.
// Reset is synchronous and active low and clears all decode state and queue
// pointers at once; no clearing pass follows. An accepted byte's command is
// written into the queue, and its first beat leaves from the output register.
`default_nettype none
module utf8_to_utf16le_transcoder #(
    parameter int COUNT_WIDTH = u8tr_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  u8tr_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output u8tr_pkg::t_out  o_out_data
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           empty;
    logic           full;
    u8tr_pkg::t_cmd cmd;
    u8tr_pkg::t_cmd head;

    // The input is held off only by a full queue, which is a registered state.
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    u8tr_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_data  (i_in_data),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    u8tr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (pop),
        .o_head (head),
        .o_empty(empty),
        .o_full (full)
    );

    // The sequencer walks each entry: units first, then the closing beat.
    u8tr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire
